FILE: rtl/wma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared defaults for the windowed moving average block.
// ----------------------------------------------------------------------------
package wma_pkg;

  // default window depth in entries
  localparam int unsigned WMA_CAPACITY    = 16;
  // default sample width, signed q8.8
  localparam int unsigned WMA_SAMPLE_BITS = 16;

endpackage

FILE: rtl/wma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/windowed_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_moving_average
// Simple moving average over a ring of the last CAPACITY samples.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  input    | in_valid_i, in_ready_o | sample_i
//  output   | out_valid_o, out_ready_i | average_o, filled_count_o,
//           |                        | average_valid_o
//
// A new sample is taken only once the last result is handed off: the ring
// read, the sum update and write-back, the bit-serial restoring divider,
// then the hand-off of the result.
// The output register lets a new sample be taken while a result waits.
// Reset clears pointer, full flag, running sum and all handshake state; the
// ring itself is not cleared, an entry is only read after it was written.
// ----------------------------------------------------------------------------
module windowed_moving_average
  import wma_pkg::*;
#(
  parameter int unsigned CAPACITY    = WMA_CAPACITY,
  parameter int unsigned SAMPLE_BITS = WMA_SAMPLE_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     average_o,
  output logic [$clog2(CAPACITY+1)-1:0]     filled_count_o,
  output logic                              average_valid_o
);

  localparam int unsigned PTR_BITS   = $clog2(CAPACITY);
  localparam int unsigned COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_BITS   = SAMPLE_BITS + PTR_BITS + 1;
  localparam int unsigned STEP_BITS  = $clog2(SUM_BITS + 1);

  localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(CAPACITY);
  localparam logic [STEP_BITS-1:0]  STEP_ALL  = STEP_BITS'(SUM_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [PTR_BITS-1:0] ptr_q, ptr_d;
  logic full_q, full_d;
  logic signed [SUM_BITS-1:0] sum_q, sum_d;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic ram_we;

  // divider state
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [SUM_BITS-1:0]   quot_q, quot_d;
  logic                  neg_q, neg_d;
  logic [STEP_BITS-1:0]  step_q, step_d;

  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_sub;
  logic                  rem_ge;

  logic signed [SUM_BITS-1:0] sum_upd;
  logic [PTR_BITS-1:0]        ptr_next;
  logic                       wrap;
  logic [SAMPLE_BITS-1:0]     quot_lo;

  logic out_valid_q, out_valid_d;
  logic out_load;
  logic signed [SAMPLE_BITS-1:0] avg_q;
  logic [COUNT_BITS-1:0] cnt_out_q;

  wma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i(sample_q),
    .raddr_i(ptr_q),
    .rdata_o(old_sample)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign ram_we     = (state_q == ST_READ);

  // running sum update for the sample held in sample_q
  assign wrap     = (ptr_q == PTR_LAST);
  assign ptr_next = wrap ? '0 : ptr_q + PTR_BITS'(1);
  assign sum_upd  = sum_q + SUM_BITS'(sample_q)
                    - (full_q ? SUM_BITS'(old_sample) : '0);

  assign rem_shift = {rem_q, quot_q[SUM_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});
  assign rem_sub   = rem_shift - {1'b0, count_q};
  assign quot_lo   = quot_q[SAMPLE_BITS-1:0];

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    full_d  = full_q;
    sum_d   = sum_q;
    count_d = count_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    neg_d   = neg_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        sum_d   = sum_upd;
        ptr_d   = ptr_next;
        full_d  = full_q | wrap;
        count_d = (full_q | wrap) ? COUNT_MAX : COUNT_BITS'(ptr_next);
        neg_d   = sum_upd[SUM_BITS-1];
        quot_d  = sum_upd[SUM_BITS-1] ? SUM_BITS'(-sum_upd) : SUM_BITS'(sum_upd);
        rem_d   = '0;
        step_d  = STEP_ALL;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        quot_d = {quot_q[SUM_BITS-2:0], rem_ge};
        step_d = step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      full_q      <= full_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_i;
    end
    count_q <= count_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    neg_q   <= neg_d;
    step_q  <= step_d;
    if (out_load) begin
      avg_q     <= neg_q ? -$signed(quot_lo) : $signed(quot_lo);
      cnt_out_q <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_o       = avg_q;
  assign filled_count_o  = cnt_out_q;
  assign average_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // a transfer in always starts the ring read
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_READ)
    else $error("accepted sample did not start a ring read");

  // once the window has wrapped it stays full
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("window full flag dropped");

  // remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < count_q)
    else $error("divider remainder out of range");

  // a shown result always counts at least one and at most all entries
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> filled_count_o != '0 && filled_count_o <= COUNT_MAX)
    else $error("filled count out of range");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_moving_average. Samples go in over a
// valid/ready channel. A small directed table covers the extremes and the
// window wrap, then a long run of random bursts follows. Every result is
// checked against an in-bench running-sum model of the ring or, for typed
// table rows, the table; first with both sides stalling and then with no stalls.
// ----------------------------------------------------------------------------
module tb;
  import wma_pkg::*;

  localparam int unsigned CAP    = WMA_CAPACITY;
  localparam int unsigned SB     = WMA_SAMPLE_BITS;
  localparam int unsigned CW     = $clog2(CAP + 1);
  localparam int unsigned SUMW   = SB + $clog2(CAP) + 1;
  localparam int          N_RAND = 2000;
  localparam int          N_DIR  = 23;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 64;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] average;
    logic [CW-1:0]        filled_count;
    logic                 average_valid;
  } avg_result_t;

  typedef struct packed {
    logic signed [SB-1:0] sample;
    logic                 typed;
    logic signed [SB-1:0] average;
    logic [CW-1:0]        filled_count;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [SB-1:0] sample_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [SB-1:0] average_o;
  logic [CW-1:0]        filled_count_o;
  logic                 average_valid_o;

  windowed_moving_average i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .average_o      (average_o),
    .filled_count_o (filled_count_o),
    .average_valid_o(average_valid_o)
  );

  // shadow of the ring, pointer, full flag and running sum
  logic signed [SB-1:0]   ring_entries [CAP];
  logic [$clog2(CAP)-1:0] ring_wr_ptr = '0;
  logic                   ring_wrapped = 1'b0;
  logic signed [SUMW-1:0] ring_sum = '0;

  avg_result_t pending_averages [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          err_count = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          window_wraps = 0;
  int          cycle_count = 0;

  // sample, typed, average, filled_count
  dir_row_t dir_rows [N_DIR] = '{
    '{S_MAX,        1'b1, S_MAX, CW'(1)},
    '{S_MIN,        1'b1, '0,    CW'(2)},  // sum of -1 over two truncates to zero
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b0, '0,    '0},
    '{S_MIN,        1'b1, S_MIN, CW'(CAP)},  // wrap drops the lone max entry
    '{S_MAX,        1'b0, '0,    '0},
    '{SB'('h5555),  1'b0, '0,    '0},
    '{SB'('haaaa),  1'b0, '0,    '0},
    '{SB'(1),       1'b0, '0,    '0},
    '{{SB{1'b1}},   1'b0, '0,    '0},
    '{'0,           1'b0, '0,    '0}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic advance_window(input logic signed [SB-1:0] smp, output avg_result_t res);
    int count;
    if (ring_wrapped) ring_sum = ring_sum - ring_entries[ring_wr_ptr];
    ring_entries[ring_wr_ptr] = smp;
    ring_sum = ring_sum + smp;
    if (ring_wr_ptr == CAP - 1) begin
      ring_wrapped = 1'b1;
      window_wraps++;
    end
    ring_wr_ptr = ring_wr_ptr + 1'b1;
    count = ring_wrapped ? CAP : int'(ring_wr_ptr);
    res.average       = SB'(ring_sum / count);
    res.filled_count  = CW'(count);
    res.average_valid = 1'b1;
  endtask

  // one transfer on the input side, with a random gap ahead of it
  task automatic send_sample(input logic signed [SB-1:0] smp, output avg_result_t res);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    advance_window(smp, res);
    samples_sent++;
  endtask

  function automatic logic signed [SB-1:0] pick_sample(input int mode);
    case (mode)
      0:       return SB'($urandom);
      1:       return $urandom_range(1) ? S_MAX : S_MIN;
      2:       return SB'(int'($urandom_range(1024)) - 512);
      default: return $urandom_range(1) ? S_MAX - SB'($urandom_range(15))
                                        : S_MIN + SB'($urandom_range(15));
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    avg_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_averages.size() == 0) begin
        $error("result transfer with nothing pending: average %0d", average_o);
        err_count++;
      end else begin
        want = pending_averages.pop_front();
        results_checked++;
        if (average_o !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, average_o);
          err_count++;
        end
        if (filled_count_o !== want.filled_count) begin
          $error("filled_count: expected %0d, got %0d", want.filled_count, filled_count_o);
          err_count++;
        end
        if (average_valid_o !== want.average_valid) begin
          $error("average_valid: expected %0b, got %0b", want.average_valid,
                 average_valid_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_averages.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    avg_result_t res;
    int burst_mode;
    int burst_left;
    burst_mode = 0;
    burst_left = 0;
    send_idle_pct = 26;
    recv_idle_pct = 58;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_sample(dir_rows[i].sample, res);
      if (dir_rows[i].typed) begin
        res.average      = dir_rows[i].average;
        res.filled_count = dir_rows[i].filled_count;
      end
      pending_averages.push_back(res);
    end

    for (int i = 0; i < N_RAND; i++) begin
      case (i * 3 / N_RAND)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // bursts of one kind of value, from a single sample up to twice the window depth
      if (burst_left == 0) begin
        burst_mode = $urandom_range(3);
        burst_left = $urandom_range(2 * CAP, 1);
      end
      burst_left--;
      send_sample(pick_sample(burst_mode), res);
      pending_averages.push_back(res);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d samples (%0d from the directed table), checked %0d averages",
             samples_sent, N_DIR, results_checked);
    $display("ring wrapped %0d times, %0d mismatches", window_wraps, err_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
